// File: rtl/lrn_across_channels_unit_macros.svh
// assertion macros for the lrn block
`ifndef LRN_ACROSS_CHANNELS_UNIT_MACROS_SVH
`define LRN_ACROSS_CHANNELS_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define LRN_ASSERT_IMP(lbl, ck, rn, a, c) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (a) |-> (c)) else $error("lrn check failed");
`define LRN_ASSERT_NXT(lbl, ck, rn, a, c) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (a) |=> (c)) else $error("lrn check failed");
`else
`define LRN_ASSERT_IMP(lbl, ck, rn, a, c)
`define LRN_ASSERT_NXT(lbl, ck, rn, a, c)
`endif
`endif

// File: rtl/lrn_pkg.sv
package lrn_pkg;

	localparam int MAX_WINDOW_DEF   = 15;
	localparam int MAX_CHANNELS_DEF = 1024;
	localparam int TAP_W            = 5;
	localparam int P_W              = 3;
	localparam int STEPS            = 24;

	localparam logic [1:0] REG_WINDOW = 2'd0;
	localparam logic [1:0] REG_ALPHA  = 2'd1;
	localparam logic [1:0] REG_BETA   = 2'd2;
	localparam logic [1:0] REG_BIAS   = 2'd3;

	localparam logic [3:0]  WINDOW_RST = 4'd5;
	localparam logic [23:0] ALPHA_RST  = 24'd209715;
	localparam logic [15:0] BETA_RST   = 16'd12288;
	localparam logic [23:0] BIAS_RST   = 24'd65536;

	typedef logic [STEPS-1:0][31:0] root_tab_t;

	typedef struct packed {
		logic             shift_in;
		logic             shift_zero;
		logic             clear;
		logic             sum_clr;
		logic             sum_step;
		logic [TAP_W-1:0] tap;
		logic             mul_lo;
		logic             mul_hi;
		logic             special;
		logic             norm_step;
		logic             log_init;
		logic             log_sq;
		logic             log_upd;
		logic             beta_mul;
		logic             exp_step;
		logic [4:0]       exp_idx;
		logic             pmul;
		logic             round;
		logic             emit;
		logic             emit_last;
	} lrn_cmd_t;

	typedef struct packed {
		logic [P_W-1:0] p;
		logic           x_zero;
		logic           s_zero;
		logic           top_set;
	} lrn_stat_t;

	function automatic logic [63:0] isqrt64(logic [63:0] v);
		logic [63:0] r;
		logic [63:0] b;
		logic [63:0] x;
		r = '0;
		b = 64'd1 << 62;
		x = v;
		for (int k = 0; k < 32; k++)
			if (b > x) b = b >> 2;
		for (int k = 0; k < 32; k++) begin
			if (b != 0) begin
				if (x >= r + b) begin
					x = x - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
		end
		return r;
	endfunction

	// 2^(2^-i) in q1.30 for i = 1..24, by repeated truncated square roots
	function automatic root_tab_t exp2_roots();
		root_tab_t   tab;
		logic [63:0] root;
		root = 64'd1 << 31;
		for (int i = 0; i < STEPS; i++) begin
			root   = isqrt64(root << 30);
			tab[i] = root[31:0];
		end
		return tab;
	endfunction

	localparam root_tab_t EXP2_ROOT = exp2_roots();

endpackage

// File: rtl/lrn_dp.sv
module lrn_dp #(
	parameter int MAX_WINDOW = lrn_pkg::MAX_WINDOW_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_addr,
	input  logic [23:0]       cfg_wdata,
	input  logic [15:0]       in_value,
	input  lrn_pkg::lrn_cmd_t cmd,
	output lrn_pkg::lrn_stat_t stat,
	output logic [15:0]       res
);

	localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int PMAX  = (MAX_WINDOW - 1) / 2;
	localparam int P_W_L = lrn_pkg::P_W;

	logic [3:0]  window_q;
	logic [23:0] alpha_q;
	logic [15:0] beta_q;
	logic [23:0] bias_q;

	logic signed [15:0] delay_q [MAX_WINDOW];
	logic [33:0]        acc_q;
	logic signed [15:0] x_q;
	logic [63:0]        s_q;
	logic [5:0]         n_q;
	logic [30:0]        m_q;
	logic [61:0]        prod_q;
	logic [23:0]        frac_q;
	logic signed [47:0] t_q;
	logic [30:0]        r_q;
	logic [46:0]        pp_q;
	logic [15:0]        res_q;

	logic [P_W_L-1:0] p_eff;
	logic [P_W_L-1:0] p_raw;
	logic signed [15:0] tap_val;
	logic signed [31:0] sq;
	logic [31:0]        mm;
	logic signed [6:0]  ip7;
	logic signed [30:0] logv;
	logic [23:0]        fp;
	logic [31:0]        root;
	logic signed [9:0]  ip;
	logic signed [10:0] sh;
	logic [10:0]        nsh;
	logic [15:0]        mag_in;
	logic [63:0]        mag;
	logic [63:0]        rnd;
	logic [16:0]        msat;
	logic [15:0]        res_d;

	assign p_raw = window_q[3:1];
	assign p_eff = (int'(p_raw) > PMAX) ? P_W_L'(PMAX) : p_raw;

	assign stat.p       = p_eff;
	assign stat.x_zero  = (x_q == 16'sd0);
	assign stat.s_zero  = (s_q == 64'd0);
	assign stat.top_set = s_q[63];

	assign tap_val = delay_q[cmd.tap[IDX_W-1:0]];
	assign sq      = tap_val * tap_val;
	assign mm      = prod_q[61:30];
	assign ip7     = $signed({1'b0, n_q}) - 7'sd36;
	assign logv    = {ip7, frac_q};
	assign fp      = t_q[37:14];
	assign root    = lrn_pkg::EXP2_ROOT[cmd.exp_idx];
	assign ip      = t_q[47:38];
	assign sh      = 11'sd30 - 11'(ip);
	assign nsh     = 11'(-sh);
	assign mag_in  = x_q[15] ? 16'(-x_q) : 16'(x_q);
	assign res     = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= lrn_pkg::WINDOW_RST;
			alpha_q  <= lrn_pkg::ALPHA_RST;
			beta_q   <= lrn_pkg::BETA_RST;
			bias_q   <= lrn_pkg::BIAS_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				lrn_pkg::REG_WINDOW: window_q <= cfg_wdata[3:0];
				lrn_pkg::REG_ALPHA:  alpha_q  <= cfg_wdata;
				lrn_pkg::REG_BETA:   beta_q   <= cfg_wdata[15:0];
				lrn_pkg::REG_BIAS:   bias_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < MAX_WINDOW; j++) delay_q[j] <= '0;
		end else if (cmd.clear) begin
			for (int j = 0; j < MAX_WINDOW; j++) delay_q[j] <= '0;
		end else if (cmd.shift_in || cmd.shift_zero) begin
			for (int j = MAX_WINDOW - 1; j > 0; j--) delay_q[j] <= delay_q[j-1];
			delay_q[0] <= cmd.shift_in ? $signed(in_value) : 16'sd0;
		end
	end

	// sum of squares, scale, log2, exponent and final rounding
	always_ff @(posedge clk) begin
		if (cmd.sum_clr) acc_q <= '0;
		if (cmd.sum_step) begin
			acc_q <= acc_q + 34'($unsigned(sq));
			if (cmd.tap == lrn_pkg::TAP_W'(p_eff)) x_q <= tap_val;
		end
		if (cmd.mul_lo) begin
			s_q <= (64'(bias_q) << 20) + 64'(alpha_q) * 64'(acc_q[16:0]);
			n_q <= 6'd63;
		end
		if (cmd.mul_hi) s_q <= s_q + ((64'(alpha_q) * 64'(acc_q[33:17])) << 17);
		if (cmd.norm_step) begin
			s_q <= s_q << 1;
			n_q <= n_q - 6'd1;
		end
		if (cmd.log_init) begin
			m_q    <= s_q[63:33];
			frac_q <= '0;
		end
		if (cmd.log_sq) prod_q <= m_q * m_q;
		if (cmd.log_upd) begin
			if (mm[31]) begin
				m_q    <= mm[31:1];
				frac_q <= {frac_q[22:0], 1'b1};
			end else begin
				m_q    <= mm[30:0];
				frac_q <= {frac_q[22:0], 1'b0};
			end
		end
		if (cmd.beta_mul) begin
			t_q <= -($signed({1'b0, beta_q}) * logv);
			r_q <= 31'd1 << 30;
		end
		if (cmd.exp_step && fp[5'd23 - cmd.exp_idx]) r_q <= 31'((63'(r_q) * 63'(root)) >> 30);
		if (cmd.pmul) pp_q <= mag_in * r_q;
		if (cmd.round || cmd.special) res_q <= res_d;
	end

	always_comb begin
		rnd = 64'(pp_q) + (64'd1 << (sh[5:0] - 6'd1));
		if (cmd.special) begin
			mag = (beta_q == 16'd0) ? 64'(mag_in) : 64'd65536;
		end else if (sh >= 11'sd48) begin
			mag = '0;
		end else if (sh > 11'sd0) begin
			mag = rnd >> sh[5:0];
		end else if (sh == 11'sd0) begin
			mag = 64'(pp_q);
		end else if (nsh >= 11'd16) begin
			mag = 64'd65536;
		end else begin
			mag = 64'(pp_q) << nsh[3:0];
		end
		if (x_q[15]) begin
			msat  = (mag > 64'd32768) ? 17'd32768 : mag[16:0];
			res_d = 16'(17'h10000 - msat);
		end else begin
			msat  = (mag > 64'd32767) ? 17'd32767 : mag[16:0];
			res_d = msat[15:0];
		end
		if (x_q == 16'sd0) res_d = '0;
	end

endmodule

// File: rtl/lrn_ctrl.sv
module lrn_ctrl #(
	parameter int MAX_WINDOW   = lrn_pkg::MAX_WINDOW_DEF,
	parameter int MAX_CHANNELS = lrn_pkg::MAX_CHANNELS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	input  logic               s_tlast,
	input  logic               out_free,
	input  lrn_pkg::lrn_stat_t stat,
	output logic               s_tready,
	output lrn_pkg::lrn_cmd_t  cmd
);

	localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int CH_W  = $clog2(MAX_CHANNELS + 1);
	localparam int EXT_W = CH_W + 5;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_SUM   = 4'd1;
	localparam logic [3:0] S_MULLO = 4'd2;
	localparam logic [3:0] S_MULHI = 4'd3;
	localparam logic [3:0] S_CHECK = 4'd4;
	localparam logic [3:0] S_NORM  = 4'd5;
	localparam logic [3:0] S_LSQ   = 4'd6;
	localparam logic [3:0] S_LUPD  = 4'd7;
	localparam logic [3:0] S_BETA  = 4'd8;
	localparam logic [3:0] S_EXP   = 4'd9;
	localparam logic [3:0] S_PMUL  = 4'd10;
	localparam logic [3:0] S_ROUND = 4'd11;
	localparam logic [3:0] S_EMIT  = 4'd12;
	localparam logic [3:0] S_NEXT  = 4'd13;

	localparam logic [4:0] LAST_STEP = 5'(lrn_pkg::STEPS - 1);

	logic [3:0]              state_q, state_d;
	logic [CH_W-1:0]         idx_q, idx_d, idx_inc;
	logic                    last_q, last_d;
	logic [lrn_pkg::P_W-1:0] f_q, f_d, p;
	logic [4:0]              cnt_q, cnt_d;
	logic [IDX_W-1:0]        tap_q, tap_d;

	assign p       = stat.p;
	assign idx_inc = (idx_q == CH_W'(MAX_CHANNELS)) ? idx_q : idx_q + CH_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
			last_q  <= 1'b0;
			f_q     <= '0;
			cnt_q   <= '0;
			tap_q   <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			last_q  <= last_d;
			f_q     <= f_d;
			cnt_q   <= cnt_d;
			tap_q   <= tap_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		idx_d       = idx_q;
		last_d      = last_q;
		f_d         = f_q;
		cnt_d       = cnt_q;
		tap_d       = tap_q;
		cmd         = '0;
		cmd.tap     = lrn_pkg::TAP_W'(tap_q);
		cmd.exp_idx = cnt_q;
		s_tready    = 1'b0;
		case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.shift_in = 1'b1;
					idx_d        = idx_inc;
					last_d       = s_tlast;
					f_d          = '0;
					if (EXT_W'(idx_inc) > EXT_W'(p)) begin
						cmd.sum_clr = 1'b1;
						tap_d       = '0;
						state_d     = S_SUM;
					end else begin
						state_d = S_NEXT;
					end
				end
			end
			S_SUM: begin
				cmd.sum_step = 1'b1;
				if (EXT_W'(tap_q) == EXT_W'({p, 1'b0})) state_d = S_MULLO;
				else tap_d = tap_q + IDX_W'(1);
			end
			S_MULLO: begin
				cmd.mul_lo = 1'b1;
				state_d    = S_MULHI;
			end
			S_MULHI: begin
				cmd.mul_hi = 1'b1;
				state_d    = S_CHECK;
			end
			S_CHECK: begin
				if (stat.x_zero || stat.s_zero) begin
					cmd.special = 1'b1;
					state_d     = S_EMIT;
				end else begin
					state_d = S_NORM;
				end
			end
			S_NORM: begin
				// one bit a cycle towards the leading one
				if (stat.top_set) begin
					cmd.log_init = 1'b1;
					cnt_d        = '0;
					state_d      = S_LSQ;
				end else begin
					cmd.norm_step = 1'b1;
				end
			end
			S_LSQ: begin
				cmd.log_sq = 1'b1;
				state_d    = S_LUPD;
			end
			S_LUPD: begin
				cmd.log_upd = 1'b1;
				if (cnt_q == LAST_STEP) begin
					state_d = S_BETA;
				end else begin
					cnt_d   = cnt_q + 5'd1;
					state_d = S_LSQ;
				end
			end
			S_BETA: begin
				cmd.beta_mul = 1'b1;
				cnt_d        = '0;
				state_d      = S_EXP;
			end
			S_EXP: begin
				cmd.exp_step = 1'b1;
				if (cnt_q == LAST_STEP) state_d = S_PMUL;
				else cnt_d = cnt_q + 5'd1;
			end
			S_PMUL: begin
				cmd.pmul = 1'b1;
				state_d  = S_ROUND;
			end
			S_ROUND: begin
				cmd.round = 1'b1;
				state_d   = S_EMIT;
			end
			S_EMIT: begin
				if (out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_last = (f_q == '0) ? (last_q && p == '0) : (f_q == p);
					state_d       = S_NEXT;
				end
			end
			S_NEXT: begin
				if (last_q && f_q != p) begin
					// flush with zero padding
					cmd.shift_zero = 1'b1;
					f_d            = f_q + 1'b1;
					if (EXT_W'(idx_q) + EXT_W'(f_q) + EXT_W'(1) > EXT_W'(p)) begin
						cmd.sum_clr = 1'b1;
						tap_d       = '0;
						state_d     = S_SUM;
					end
				end else if (last_q) begin
					cmd.clear = 1'b1;
					idx_d     = '0;
					last_d    = 1'b0;
					f_d       = '0;
					state_d   = S_IDLE;
				end else begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

// File: rtl/lrn_across_channels_unit.sv
// cross-channel local response normalisation, one pixel's channels per run
// s_* takes channel words in order, s_tlast on the pixel's final channel
// m_* gives normalised words in channel order, m_tlast on the final one
// cfg_we/cfg_addr/cfg_wdata write window size, alpha/size, beta and bias k
// outputs lag inputs by half the window; the marked word flushes the rest
// one word is worked on at a time; a result is made in these steps:
// window sum over 2p+1 taps, leading-one search one bit a cycle,
// 24 squaring steps for log2 (each a square and an update), 24 steps for exp2, then rounding
// a zero value or zero scale skips the log/exp path
// a channel that makes no result passes through the next state back to idle
// s_tready is high only while no word is in work
// a finished result waits in the output register while the next word comes in;
// a stalled receiver holds the block at its next result
// reset returns registers to defaults and clears delay line and counters
`include "lrn_across_channels_unit_macros.svh"
module lrn_across_channels_unit #(
	parameter int MAX_WINDOW   = lrn_pkg::MAX_WINDOW_DEF,
	parameter int MAX_CHANNELS = lrn_pkg::MAX_CHANNELS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // sample_value
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // norm_value
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [23:0] cfg_wdata
);

	lrn_pkg::lrn_cmd_t  cmd;
	lrn_pkg::lrn_stat_t stat;
	logic [15:0]        res;
	logic               out_free;
	logic               m_tvalid_q;
	logic [15:0]        m_tdata_q;
	logic               m_tlast_q;

	assign out_free = !m_tvalid_q || m_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

	lrn_ctrl #(
		.MAX_WINDOW  (MAX_WINDOW),
		.MAX_CHANNELS(MAX_CHANNELS)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tlast (s_tlast),
		.out_free(out_free),
		.stat    (stat),
		.s_tready(s_tready),
		.cmd     (cmd)
	);

	lrn_dp #(
		.MAX_WINDOW(MAX_WINDOW)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata),
		.in_value (s_tdata),
		.cmd      (cmd),
		.stat     (stat),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.emit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			m_tdata_q <= res;
			m_tlast_q <= cmd.emit_last;
		end
	end

	`LRN_ASSERT_IMP(a_emit_into_free, clk, arst_n, cmd.emit, !m_tvalid || m_tready)
	`LRN_ASSERT_NXT(a_emit_shows, clk, arst_n, cmd.emit, m_tvalid)
	`LRN_ASSERT_IMP(a_no_accept_in_emit, clk, arst_n, s_tready, !cmd.emit && !cmd.sum_step)

endmodule
